FILE: hw/rtl/cbh_pkg.sv
package cbh_pkg;

  // Field widths fixed by the interface.
  localparam int VOLT_W    = 16;
  localparam int TOL_W     = 16;
  localparam int MOD_IDX_W = 6;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  // Sums against the minimum are formed one bit wider so they never wrap.
  localparam int SUM_W = VOLT_W + 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_TOL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_TOL  = CFG_IDX_W'(1);

  // One voltage request.
  typedef struct packed {
    logic [VOLT_W-1:0] voltage_mv;
    logic              last_module;
  } cbh_in_t;

  // One module decision.
  typedef struct packed {
    logic [MOD_IDX_W-1:0] module_index;
    logic                 discharge;
    logic                 last_result;
  } cbh_out_t;

  // Operations of the shared arithmetic unit.
  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_LT  = 1'b1
  } cbh_alu_op_t;

  // Operand bundle handed to the shared arithmetic unit.
  typedef struct packed {
    cbh_alu_op_t      op;
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
  } cbh_alu_req_t;

  // Results of the shared arithmetic unit.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             lt;
  } cbh_alu_rsp_t;

endpackage

FILE: hw/rtl/cbh_ram.sv
module cbh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port that holds while idle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/cbh_alu.sv
module cbh_alu
  import cbh_pkg::*;
(
  input  cbh_alu_req_t req,
  output cbh_alu_rsp_t rsp
);

  logic [SUM_W:0] diff;

  // One adder and one subtract-based compare; the sequencer picks what it needs.
  assign diff    = {1'b0, req.a} - {1'b0, req.b};
  assign rsp.sum = (req.op == ALU_ADD) ? (req.a + req.b) : diff[SUM_W-1:0];
  assign rsp.lt  = diff[SUM_W];

endmodule

FILE: hw/rtl/cell_balance_hysteresis_unit.sv
// Passive cell balancing against the lowest module, with hysteresis. Module voltages
// arrive one request each, in module order, and the final module of a round carries
// last_module. Each voltage is stored and the block tracks the round's lowest voltage.
// On the final module the block forms lowest + start tolerance and lowest + stop
// tolerance, then walks the stored modules and emits one decision each in index order:
// it reads the stored voltage, tests it against the start threshold, tests it against
// the stop threshold only when the start test misses, and emits the decision, holding
// while the output is stalled. All of this goes through one shared adder/comparator.
// A module's discharge bit is set above the start threshold, cleared below the stop
// threshold and kept otherwise; the bits persist across rounds and reset clears them.
// Voltages beyond MODULE_COUNT_MAX in one round are dropped, but a marker on a dropped
// voltage still ends the round. The tolerance registers are written through the cfg
// port, which is always ready.
module cell_balance_hysteresis_unit
  import cbh_pkg::*;
#(
  parameter int MODULE_COUNT_MAX = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cbh_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cbh_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int CntW  = $clog2(MODULE_COUNT_MAX + 1);
  localparam int AddrW = (MODULE_COUNT_MAX > 1) ? $clog2(MODULE_COUNT_MAX) : 1;
  localparam logic [CntW-1:0] CntMax = CntW'(MODULE_COUNT_MAX);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_UPPER   = 7'b0000010,
    S_LOWER   = 7'b0000100,
    S_READ    = 7'b0001000,
    S_TEST_HI = 7'b0010000,
    S_TEST_LO = 7'b0100000,
    S_EMIT    = 7'b1000000
  } state_t;

  state_t                  state;
  logic [TOL_W-1:0]        start_tol;
  logic [TOL_W-1:0]        stop_tol;
  logic [CntW-1:0]         load_count;
  logic [VOLT_W-1:0]       run_min;
  logic [CntW-1:0]         walk;
  logic [SUM_W-1:0]        upper;
  logic [SUM_W-1:0]        lower;
  logic [MODULE_COUNT_MAX-1:0] disch_bits;

  logic              in_acc;
  logic              room;
  logic              out_free;
  logic              emit_fire;
  logic [CntW-1:0]   walk_inc;
  logic              walk_last;
  logic [VOLT_W-1:0] ram_rdata;
  cbh_alu_req_t      alu_req;
  cbh_alu_rsp_t      alu_rsp;

  // Handshake decodes.
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && (state == S_IDLE);
  assign room      = (load_count < CntMax);
  assign out_free  = !out_valid || !out_stall;
  assign emit_fire = (state == S_EMIT) && out_free;
  assign walk_inc  = walk + CntW'(1);
  assign walk_last = (walk_inc == load_count);

  // Voltage store: written while loading, read once per module during the walk.
  cbh_ram #(
    .WIDTH(VOLT_W),
    .DEPTH(MODULE_COUNT_MAX)
  ) u_store (
    .clk  (clk),
    .we   (in_acc && room),
    .waddr(load_count[AddrW-1:0]),
    .wdata(in_data.voltage_mv),
    .re   (state == S_READ),
    .raddr(walk[AddrW-1:0]),
    .rdata(ram_rdata)
  );

  // Operand selection for the shared unit, one use per sequencer state.
  always_comb begin
    alu_req.op = ALU_LT;
    alu_req.a  = '0;
    alu_req.b  = '0;
    case (state)
      S_IDLE: begin
        alu_req.a = {1'b0, in_data.voltage_mv};
        alu_req.b = {1'b0, run_min};
      end
      S_UPPER: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = {1'b0, run_min};
        alu_req.b  = {1'b0, start_tol};
      end
      S_LOWER: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = {1'b0, run_min};
        alu_req.b  = {1'b0, stop_tol};
      end
      S_TEST_HI: begin
        alu_req.a = upper;
        alu_req.b = {1'b0, ram_rdata};
      end
      S_TEST_LO: begin
        alu_req.a = {1'b0, ram_rdata};
        alu_req.b = lower;
      end
      default: begin
        alu_req.op = ALU_LT;
      end
    endcase
  end

  cbh_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_tol <= '0;
      stop_tol  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_TOL: start_tol <= cfg_data;
        CFG_STOP_TOL:  stop_tol  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer: load voltages, form thresholds, then walk the stored modules.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      load_count <= '0;
      run_min    <= '1;
      walk       <= '0;
      disch_bits <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (room) begin
              load_count <= load_count + CntW'(1);
              if (alu_rsp.lt) begin
                run_min <= in_data.voltage_mv;
              end
            end
            if (in_data.last_module) begin
              walk  <= '0;
              state <= S_UPPER;
            end
          end
        end
        S_UPPER: begin
          state <= S_LOWER;
        end
        S_LOWER: begin
          state <= S_READ;
        end
        S_READ: begin
          state <= S_TEST_HI;
        end
        S_TEST_HI: begin
          if (alu_rsp.lt) begin
            disch_bits[walk[AddrW-1:0]] <= 1'b1;
            state <= S_EMIT;
          end else begin
            state <= S_TEST_LO;
          end
        end
        S_TEST_LO: begin
          if (alu_rsp.lt) begin
            disch_bits[walk[AddrW-1:0]] <= 1'b0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (walk_last) begin
              load_count <= '0;
              run_min    <= '1;
              state      <= S_IDLE;
            end else begin
              walk  <= walk_inc;
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Thresholds are captured from the shared adder.
  always_ff @(posedge clk) begin
    if (state == S_UPPER) begin
      upper <= alu_rsp.sum;
    end
    if (state == S_LOWER) begin
      lower <= alu_rsp.sum;
    end
  end

  // Output register; it frees the sequencer while a decision waits downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data.module_index <= MOD_IDX_W'(walk);
      out_data.discharge    <= disch_bits[walk[AddrW-1:0]];
      out_data.last_result  <= walk_last;
    end
  end

`ifndef SYNTHESIS
  // The fill count never passes the store's capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    load_count <= CntMax)
    else $error("load count beyond capacity");

  // The walk only visits modules that were loaded this round.
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_TEST_HI || state == S_TEST_LO || state == S_EMIT)
    |-> (walk < load_count))
    else $error("walk index outside the loaded modules");

  // The final decision of a round returns the block to loading with a fresh round.
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && walk_last) |=> (state == S_IDLE && load_count == '0 && run_min == '1))
    else $error("round state not cleared after the final decision");

  // A new decision only appears after the emit step.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("output became valid outside the emit step");
`endif

endmodule
